### design/asa_pkg.sv
package asa_pkg;

    // Field and register widths.
    localparam int ORI_W   = 32;
    localparam int ACC_W   = 26;
    localparam int SLOW_W  = 19;
    localparam int TR_W    = 19;
    localparam int TTT_W   = 25;
    localparam int MROT_W  = 25;
    localparam int MACC_W  = 25;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int FRAC_BITS_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [SLOW_W-1:0] SLOW_RST = SLOW_W'(32768);
    localparam logic [TR_W-1:0]   TR_RST   = TR_W'(3277);
    localparam logic [TTT_W-1:0]  TTT_RST  = TTT_W'(6554);
    localparam logic [MROT_W-1:0] MROT_RST = MROT_W'(65536);
    localparam logic [MACC_W-1:0] MACC_RST = MACC_W'(262144);

    // 180/pi in Q24 and pi/180 in Q32.
    localparam logic [29:0] RAD2DEG_Q24 = 30'd961263669;
    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

    localparam logic [9:0] DEG_FULL = 10'd360;
    localparam logic [8:0] DEG_HALF = 9'd180;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_SLOW_RADIUS   = 3'd0,
        REG_TARGET_RADIUS = 3'd1,
        REG_TIME_TO_TGT   = 3'd2,
        REG_MAX_ROTATION  = 3'd3,
        REG_MAX_ACCEL     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [ORI_W-1:0] target_orientation;
        logic signed [ORI_W-1:0] own_orientation;
    } in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] angular_accel;
        logic                    inside_target;
    } out_t;

    typedef struct packed {
        logic [SLOW_W-1:0] slow_radius;
        logic [TR_W-1:0]   target_radius;
        logic [TTT_W-1:0]  time_to_target;
        logic [MROT_W-1:0] max_rotation;
        logic [MACC_W-1:0] max_angular_accel;
    } cfg_t;

    // Per-word flags that ride alongside the dividers.
    typedef struct packed {
        logic big;
        logic rneg;
        logic in_target;
    } ctl_t;

endpackage

### design/align_steering_angular.sv
// Angular alignment steering, one result word per input word. The block
// takes a word every clock cycle unless a finished result is held at the
// output. Each result passes seven front stages (difference, degree
// conversion, reduction modulo 360, wrap and conversion back to radians,
// radius checks), a 25-stage pipelined divider for the proportional rate,
// one stage that forms the acceleration dividend and its overflow check, a
// second 25-stage divider by the time to target, and an output register.
// The whole pipeline holds while a finished result waits and the consumer
// is not ready. Configuration is written over the APB-style port at byte
// address 4*i and must only change while the pipeline is empty.
module align_steering_angular #(
    parameter int FRAC_BITS = asa_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [asa_pkg::ADDR_W-1:0]  paddr,
    input  logic [asa_pkg::DATA_W-1:0]  pwdata,
    output logic [asa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  asa_pkg::in_t                item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output asa_pkg::out_t               result
);
    import asa_pkg::*;

    localparam int AMT_W  = FRAC_BITS + 2;
    localparam int PROD_W = MROT_W + AMT_W;
    localparam int N1_W   = MROT_W + SLOW_W;
    localparam int N2_W   = MACC_W + TTT_W;

    cfg_t      cfg_reg;
    reg_idx_t  widx;
    logic      wr;

    logic              en;
    logic              front_valid;
    logic [PROD_W-1:0] prod;
    ctl_t              fctl;

    logic              d1_valid;
    logic [MROT_W-1:0] q1;
    ctl_t              d1_ctl;

    logic              mid_valid_reg;
    logic [N2_W-1:0]   n2_reg;
    logic [2:0]        mid_sb_reg;
    logic [MROT_W-1:0] rate;
    logic [N2_W-1:0]   n2_next;
    logic              ovf_next;

    logic              d2_valid;
    logic [MACC_W-1:0] q2;
    logic [2:0]        d2_sb;

    logic              out_valid_reg;
    out_t              out_reg;
    out_t              out_next;
    logic [MACC_W-1:0] acc;

    // Configuration write and read.
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_radius       <= SLOW_RST;
            cfg_reg.target_radius     <= TR_RST;
            cfg_reg.time_to_target    <= TTT_RST;
            cfg_reg.max_rotation      <= MROT_RST;
            cfg_reg.max_angular_accel <= MACC_RST;
        end
        else if (wr)
        begin
            case (widx)
                REG_SLOW_RADIUS:   cfg_reg.slow_radius       <= pwdata[SLOW_W-1:0];
                REG_TARGET_RADIUS: cfg_reg.target_radius     <= pwdata[TR_W-1:0];
                REG_TIME_TO_TGT:   cfg_reg.time_to_target    <= pwdata[TTT_W-1:0];
                REG_MAX_ROTATION:  cfg_reg.max_rotation      <= pwdata[MROT_W-1:0];
                REG_MAX_ACCEL:     cfg_reg.max_angular_accel <= pwdata[MACC_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_SLOW_RADIUS:   prdata = DATA_W'(cfg_reg.slow_radius);
            REG_TARGET_RADIUS: prdata = DATA_W'(cfg_reg.target_radius);
            REG_TIME_TO_TGT:   prdata = DATA_W'(cfg_reg.time_to_target);
            REG_MAX_ROTATION:  prdata = DATA_W'(cfg_reg.max_rotation);
            REG_MAX_ACCEL:     prdata = DATA_W'(cfg_reg.max_angular_accel);
            default:           prdata = '0;
        endcase
    end

    // The pipeline advances unless a finished word is held at the output.
    assign en         = !out_valid_reg || result_ready;
    assign item_ready = en;

    asa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid       (item_valid),
        .item        (item),
        .cfg         (cfg_reg),
        .front_valid (front_valid),
        .prod        (prod),
        .ctl         (fctl)
    );

    // Proportional rate: max_rotation * angle / slow_radius.
    asa_divider #(
        .Q_W  (MROT_W),
        .D_W  (SLOW_W),
        .SB_W (3)
    ) u_div_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (front_valid),
        .num       (N1_W'(prod)),
        .den       (cfg_reg.slow_radius),
        .sb        (fctl),
        .quo_valid (d1_valid),
        .quo       (q1),
        .quo_sb    (d1_ctl)
    );

    // Rate selection, acceleration dividend and its overflow check. The
    // quotient overflows its width exactly when the dividend reaches the
    // divisor shifted by the quotient width, and then saturates anyway.
    always_comb
    begin
        rate     = d1_ctl.big ? cfg_reg.max_rotation : q1;
        n2_next  = N2_W'(rate) << FRAC_BITS;
        ovf_next = n2_next >= {cfg_reg.time_to_target, {MACC_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg     <= n2_next;
            mid_sb_reg <= {ovf_next, d1_ctl.rneg, d1_ctl.in_target};
        end
    end

    // Acceleration: rate / time_to_target.
    asa_divider #(
        .Q_W  (MACC_W),
        .D_W  (TTT_W),
        .SB_W (3)
    ) u_div_accel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (mid_valid_reg),
        .num       (n2_reg),
        .den       (cfg_reg.time_to_target),
        .sb        (mid_sb_reg),
        .quo_valid (d2_valid),
        .quo       (q2),
        .quo_sb    (d2_sb)
    );

    // Saturation, sign and the inside-target case.
    always_comb
    begin
        if (d2_sb[2] || (q2 > cfg_reg.max_angular_accel))
        begin
            acc = cfg_reg.max_angular_accel;
        end
        else
        begin
            acc = q2;
        end
        out_next.inside_target = d2_sb[0];
        if (d2_sb[0])
        begin
            out_next.angular_accel = '0;
        end
        else if (d2_sb[1])
        begin
            out_next.angular_accel = ACC_W'(0) - ACC_W'(acc);
        end
        else
        begin
            out_next.angular_accel = ACC_W'(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### design/asa_front.sv
module asa_front #(
    parameter int FRAC_BITS = asa_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  valid,
    input  asa_pkg::in_t                          item,
    input  asa_pkg::cfg_t                         cfg,
    output logic                                  front_valid,
    output logic [asa_pkg::MROT_W+FRAC_BITS+1:0]  prod,
    output asa_pkg::ctl_t                         ctl
);
    import asa_pkg::*;

    localparam int DEG_W  = 39 - FRAC_BITS;
    localparam int QD_W   = DEG_W - 8;
    localparam int AMT_W  = FRAC_BITS + 2;
    localparam int PROD_W = MROT_W + AMT_W;
    localparam longint unsigned MOD_M = (64'd1 << (DEG_W + 8)) / 360;
    localparam logic [DEG_W-1:0] MOD_MUL = DEG_W'(MOD_M);

    logic [6:0] v_reg;

    logic [32:0]       mag_reg;
    logic [5:1]        neg_reg;
    logic [45:0]       plo_reg;
    logic [46:0]       phi_reg;
    logic [DEG_W-1:0]  deg_reg;
    logic [DEG_W-1:0]  deg4_reg;
    logic [QD_W-1:0]   q_reg;
    logic [8:0]        r_reg;
    logic [AMT_W-1:0]  amt_reg;
    logic              rneg_reg;
    logic [PROD_W-1:0] prod_reg;
    ctl_t              ctl_reg;

    logic [32:0]         diff;
    logic [32:0]         mag_next;
    logic [45:0]         plo_next;
    logic [46:0]         phi_next;
    logic [62:0]         sum;
    logic [DEG_W-1:0]    deg_next;
    logic [2*DEG_W-1:0]  mprod;
    logic [DEG_W:0]      qe;
    logic [DEG_W:0]      qx;
    logic [DEG_W:0]      rfull;
    logic [9:0]          r10;
    logic [8:0]          r_next;
    logic [7:0]          adeg;
    logic                rneg_next;
    logic [34:0]         dsum;
    logic [AMT_W-1:0]    amt_next;
    logic [PROD_W-1:0]   prod_next;
    ctl_t                ctl_next;

    // Stage one: difference and its magnitude.
    always_comb
    begin
        diff = {item.target_orientation[ORI_W-1], item.target_orientation}
             - {item.own_orientation[ORI_W-1], item.own_orientation};
        mag_next = diff[32] ? (33'd0 - diff) : diff;
    end

    // Stage two: magnitude times 180/pi, split in two partial products.
    always_comb
    begin
        plo_next = 46'(mag_reg[15:0]) * 46'(RAD2DEG_Q24);
        phi_next = 47'(mag_reg[32:16]) * 47'(RAD2DEG_Q24);
    end

    // Stage three: whole degrees, truncated.
    always_comb
    begin
        sum = (63'(phi_reg) << 16) + 63'(plo_reg);
        deg_next = sum[FRAC_BITS+24+DEG_W-1:FRAC_BITS+24];
    end

    // Stage four: quotient by 360 through a reciprocal, possibly one low.
    assign mprod = (2*DEG_W)'(deg_reg) * (2*DEG_W)'(MOD_MUL);

    // Stage five: remainder with a single correction step.
    always_comb
    begin
        qe = (DEG_W+1)'(q_reg);
        qx = (qe << 8) + (qe << 6) + (qe << 5) + (qe << 3);
        rfull = {1'b0, deg4_reg} - qx;
        r10 = rfull[9:0];
        r_next = (r10 >= DEG_FULL) ? 9'(r10 - DEG_FULL) : r10[8:0];
    end

    // Stage six: wrap into -180..180 and convert back to radians.
    always_comb
    begin
        if (r_reg > DEG_HALF)
        begin
            adeg = 8'(DEG_FULL - 10'(r_reg));
            rneg_next = !neg_reg[5];
        end
        else
        begin
            adeg = r_reg[7:0];
            rneg_next = neg_reg[5] && (r_reg != 9'd0);
        end
        dsum = 35'(adeg) * 35'(DEG2RAD_Q32) + (35'd1 << (31 - FRAC_BITS));
        amt_next = dsum[32-FRAC_BITS+AMT_W-1:32-FRAC_BITS];
    end

    // Stage seven: radius checks and the proportional numerator.
    always_comb
    begin
        ctl_next.in_target = (amt_reg == '0) || (32'(amt_reg) < 32'(cfg.target_radius));
        ctl_next.big       = 32'(amt_reg) > 32'(cfg.slow_radius);
        ctl_next.rneg      = rneg_reg;
        prod_next = PROD_W'(cfg.max_rotation) * PROD_W'(amt_reg);
    end

    // Valid bits for the seven stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], valid};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= mag_next;
            neg_reg[1] <= diff[32];
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            neg_reg[2] <= neg_reg[1];
            deg_reg    <= deg_next;
            neg_reg[3] <= neg_reg[2];
            q_reg      <= mprod[2*DEG_W-1:DEG_W+8];
            deg4_reg   <= deg_reg;
            neg_reg[4] <= neg_reg[3];
            r_reg      <= r_next;
            neg_reg[5] <= neg_reg[4];
            amt_reg    <= amt_next;
            rneg_reg   <= rneg_next;
            prod_reg   <= prod_next;
            ctl_reg    <= ctl_next;
        end
    end

    assign front_valid = v_reg[6];
    assign prod        = prod_reg;
    assign ctl         = ctl_reg;

endmodule

### design/asa_divider.sv
module asa_divider #(
    parameter int Q_W  = 25,
    parameter int D_W  = 19,
    parameter int SB_W = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid,
    input  logic [Q_W+D_W-1:0] num,
    input  logic [D_W-1:0]     den,
    input  logic [SB_W-1:0]    sb,
    output logic               quo_valid,
    output logic [Q_W-1:0]     quo,
    output logic [SB_W-1:0]    quo_sb
);
    import asa_pkg::*;

    logic [Q_W-1:0]  v_reg;
    logic [D_W-1:0]  rem_reg [Q_W];
    logic [Q_W-1:0]  sr_reg  [Q_W];
    logic [SB_W-1:0] sb_reg  [Q_W];

    // One quotient bit per stage, restoring form. The quotient bits shift
    // into the low end while the dividend's low bits leave at the top.
    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [D_W-1:0]  rem_src;
        logic [Q_W-1:0]  sr_src;
        logic [SB_W-1:0] sb_src;
        logic            v_src;
        logic [D_W:0]    trial;
        logic            ge;
        logic [D_W:0]    diffv;

        if (k == 0)
        begin : g_first
            assign rem_src = num[Q_W+D_W-1:Q_W];
            assign sr_src  = num[Q_W-1:0];
            assign sb_src  = sb;
            assign v_src   = valid;
        end
        else
        begin : g_next
            assign rem_src = rem_reg[k-1];
            assign sr_src  = sr_reg[k-1];
            assign sb_src  = sb_reg[k-1];
            assign v_src   = v_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_src, sr_src[Q_W-1]};
            ge    = trial >= {1'b0, den};
            diffv = trial - {1'b0, den};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diffv[D_W-1:0] : trial[D_W-1:0];
                sr_reg[k]  <= {sr_src[Q_W-2:0], ge};
                sb_reg[k]  <= sb_src;
            end
        end
    end

    assign quo_valid = v_reg[Q_W-1];
    assign quo       = sr_reg[Q_W-1];
    assign quo_sb    = sb_reg[Q_W-1];

endmodule

### test/align_steering_angular_tb.sv
module align_steering_angular_tb;
    import asa_pkg::*;

    localparam int LATENCY = 59;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_ready;
    in_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_t result;

    // Shadow copy of the configuration registers.
    logic [SLOW_W-1:0] sh_slow;
    logic [TR_W-1:0]   sh_tr;
    logic [TTT_W-1:0]  sh_ttt;
    logic [MROT_W-1:0] sh_mrot;
    logic [MACC_W-1:0] sh_macc;

    out_t steer_q[$];
    int errors = 0;
    int results_seen = 0;
    int inside_seen = 0;
    int rx_idle_pct = 15;
    int rx_hold = 0;

    align_steering_angular u_top (.*);

    always #2 clk = ~clk;

    // Expected steering for one orientation pair.
    function automatic out_t steer_calc(in_t w);
        logic signed [63:0] diff, deg;
        logic [63:0] mag, adeg, amount, rate, acc;
        logic neg, rneg;
        out_t r;
        diff = 64'(w.target_orientation) - 64'(w.own_orientation);
        neg = diff < 0;
        mag = neg ? -diff : diff;
        deg = (mag * 64'd961263669) >> 40;
        if (neg)
            deg = -deg;
        deg = deg % 360;
        if (deg > 180)
            deg = deg - 360;
        else if (deg < -180)
            deg = deg + 360;
        rneg = deg < 0;
        adeg = rneg ? -deg : deg;
        amount = (adeg * 64'd74961321 + (64'd1 << 15)) >> 16;
        r = '0;
        if (amount == 0 || amount < sh_tr)
        begin
            r.inside_target = 1'b1;
            return r;
        end
        if (amount > sh_slow)
            rate = sh_mrot;
        else
            rate = (64'(sh_mrot) * amount) / sh_slow;
        if (sh_ttt == 0)
            acc = sh_macc;
        else
            acc = (rate << 16) / sh_ttt;
        if (acc > sh_macc)
            acc = sh_macc;
        r.angular_accel = ACC_W'(rneg ? -acc : acc);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // APB write: setup cycle then access cycle.
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_SLOW_RADIUS:   sh_slow = val[SLOW_W-1:0];
            REG_TARGET_RADIUS: sh_tr = val[TR_W-1:0];
            REG_TIME_TO_TGT:   sh_ttt = val[TTT_W-1:0];
            REG_MAX_ROTATION:  sh_mrot = val[MROT_W-1:0];
            default:           sh_macc = val[MACC_W-1:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] s, logic [31:0] t, logic [31:0] ttt,
                              logic [31:0] mr, logic [31:0] ma);
        write_reg(REG_SLOW_RADIUS, s);
        write_reg(REG_TARGET_RADIUS, t);
        write_reg(REG_TIME_TO_TGT, ttt);
        write_reg(REG_MAX_ROTATION, mr);
        write_reg(REG_MAX_ACCEL, ma);
    endtask

    // Send one word, idling at random beforehand. Entered at a falling edge
    // and left at the falling edge after acceptance, with valid still high,
    // so that words can follow one another without a gap.
    task automatic send_word(logic [31:0] tgt, logic [31:0] own, bit may_idle);
        in_t w;
        w.target_orientation = tgt;
        w.own_orientation = own;
        if (may_idle)
            while ($urandom_range(99) < 15)
            begin
                item_valid <= 1'b0;
                @(negedge clk);
            end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        steer_q.push_back(steer_calc(w));
        @(negedge clk);
    endtask

    // Drop valid and wait until every word has come back; ends at a falling edge.
    task automatic drain;
        item_valid <= 1'b0;
        while (steer_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (steer_q.size() == 0)
            begin
                report_mismatch("unexpected word", 32'(result), 32'h0);
            end
            else
            begin
                want = steer_q.pop_front();
                results_seen++;
                if (want.inside_target)
                    inside_seen++;
                if (result.angular_accel !== want.angular_accel)
                    report_mismatch("angular_accel", 32'(result.angular_accel),
                                    32'(want.angular_accel));
                if (result.inside_target !== want.inside_target)
                    report_mismatch("inside_target", 32'(result.inside_target),
                                    32'(want.inside_target));
            end
        end
    end

    // Receiver readiness, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic test_directed;
        logic [31:0] ext[8];
        ext = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                32'h0003243F, 32'hFFFCDBC1, 32'h00010000};
        set_config(32768, 3277, 6554, 65536, 262144);
        // Zero difference, extremes, half turn either way, small angles.
        send_word(32'h0, 32'h0, 0);
        send_word(32'h7FFFFFFF, 32'h80000000, 0);
        send_word(32'h80000000, 32'h7FFFFFFF, 0);
        send_word(32'h0003243F, 32'h0, 0);
        send_word(32'h0, 32'h0003243F, 0);
        send_word(32'h00000400, 32'h0, 0);
        send_word(32'h00040000, 32'h0, 0);
        send_word(32'h00030000, 32'h0, 0);
        send_word(32'hFFFD0000, 32'h0, 0);
        send_word(32'h00050000, 32'h0, 0);
        for (int i = 0; i < 8; i++)
            send_word(ext[i], ext[7 - i], 0);
        drain();
        // Zero time to target saturates; zero rates give zero output.
        set_config(0, 0, 0, 16777216, 16777216);
        send_word(32'h00010000, 32'h0, 0);
        send_word(32'h0, 32'h00010000, 0);
        drain();
        set_config(262144, 262144, 1, 0, 0);
        send_word(32'h00080000, 32'h0, 0);
        send_word(32'h0, 32'h00080000, 0);
        drain();
    endtask

    task automatic test_random(int n, bit may_idle);
        logic [31:0] a, b;
        for (int i = 0; i < n; i++)
        begin
            a = $urandom();
            case ($urandom_range(2))
                0: b = $urandom();
                1: b = a + $urandom_range(32'h00080000) - 32'h00040000;
                default: b = a - $urandom_range(32'h00070000);
            endcase
            send_word(a, b, may_idle);
        end
        drain();
    endtask

    task automatic test_configs;
        set_config($urandom_range(1, 262144), $urandom_range(262144), $urandom_range(1, 16777216),
                   $urandom_range(16777216), $urandom_range(16777216));
        test_random(150, 1);
        set_config(1, 0, 16777216, 16777216, 16777216);
        test_random(100, 1);
        set_config(262144, 1, 1, 1, 16777216);
        test_random(100, 1);
        set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        test_random(100, 1);
        set_config(32768, 3277, 6554, 65536, 262144);
    endtask

    task automatic test_backpressure;
        // Long receiver stall while words keep arriving.
        rx_hold = 200;
        test_random(150, 0);
        rx_idle_pct = 0;
        test_random(200, 0);
        rx_idle_pct = 15;
    endtask

    initial
    begin
        sh_slow = SLOW_RST;
        sh_tr = TR_RST;
        sh_ttt = TTT_RST;
        sh_mrot = MROT_RST;
        sh_macc = MACC_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(250, 1);
        test_configs();
        test_backpressure();
        $display("Covered %0d words (%0d inside target) over several register settings,",
                 results_seen, inside_seen);
        $display("including zero and full-scale limits and a long receiver stall.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
